// ===== rtl/mf3_pkg.sv =====
package mf3_pkg;

	localparam int LANE_W    = 16;
	localparam int NUM_CH    = 4;
	localparam int PIX_W     = LANE_W * NUM_CH;
	localparam int NUM_CELLS = 9;
	localparam int CFG_IDX_W = 4;
	localparam int Q_DEPTH   = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_MASK  = 4'd2;

	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;
	localparam logic [63:0] RST_MEDIAN_MASK  = 64'h0000_FFFF_FFFF_FFFF;

	typedef logic [PIX_W-1:0]  pixel_t;
	typedef logic [LANE_W-1:0] lane_t;

	typedef struct packed {
		logic  mode;
		lane_t in_blue;
		lane_t in_green;
		lane_t in_red;
		lane_t in_alpha;
	} in_item_t;

	typedef struct packed {
		lane_t out_blue;
		lane_t out_green;
		lane_t out_red;
		lane_t out_alpha;
		logic  frame_done;
	} out_item_t;

	typedef struct packed {
		pixel_t [NUM_CELLS-1:0] cells;
		pixel_t                 orig;
		logic                   done;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		lane_t lo;
		lane_t md;
		lane_t hi;
	} sort3_t;

	function automatic sort3_t sort3(input lane_t a, input lane_t b, input lane_t c);
		lane_t  mn_ab;
		lane_t  mx_ab;
		lane_t  mn_mc;
		sort3_t r;
		mn_ab = (a < b) ? a : b;
		mx_ab = (a < b) ? b : a;
		mn_mc = (mx_ab < c) ? mx_ab : c;
		r.lo  = (mn_ab < c) ? mn_ab : c;
		r.hi  = (mx_ab > c) ? mx_ab : c;
		r.md  = (mn_ab > mn_mc) ? mn_ab : mn_mc;
		return r;
	endfunction

	function automatic lane_t med3(input lane_t a, input lane_t b, input lane_t c);
		sort3_t r;
		r = sort3(a, b, c);
		return r.md;
	endfunction

	function automatic lane_t max3(input lane_t a, input lane_t b, input lane_t c);
		sort3_t r;
		r = sort3(a, b, c);
		return r.hi;
	endfunction

	function automatic lane_t min3(input lane_t a, input lane_t b, input lane_t c);
		sort3_t r;
		r = sort3(a, b, c);
		return r.lo;
	endfunction

endpackage

// ===== rtl/mf3_ram.sv =====
module mf3_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

// ===== rtl/mf3_front.sv =====
module mf3_front #(
	parameter int MAX_WIDTH    = 2048,
	parameter int CHANNEL_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mf3_pkg::in_item_t  in_data,
	input  logic [11:0]        image_width,
	input  logic [15:0]        image_height,
	input  logic               size_wr,
	output logic               div_busy,
	output logic               q_push,
	output mf3_pkg::q_entry_t  q_data,
	input  mf3_pkg::q_status_t q_stat
);
	import mf3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int W_W0  = $clog2(MAX_WIDTH + 1);
	localparam int W_W   = (W_W0 > 12) ? W_W0 : 12;
	localparam int ROW_W = 17;
	localparam int POS_W = 32;
	localparam int OY_W  = 16;
	localparam logic [W_W-1:0] MAX_W = W_W'(MAX_WIDTH);
	localparam logic [W_W-1:0] MIN_W = W_W'(3);
	localparam int RST_W = (MAX_WIDTH < int'(RST_IMAGE_WIDTH)) ? MAX_WIDTH
		: int'(RST_IMAGE_WIDTH);
	localparam logic [POS_W-1:0] RST_TOTAL = POS_W'(RST_W * int'(RST_IMAGE_HEIGHT));

	// sizes and counters
	logic [W_W-1:0]   w;
	logic [OY_W-1:0]  h;
	logic [POS_W-1:0] total_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [POS_W-1:0] emitted_q;
	logic [COL_W-1:0] ox_q;
	logic [OY_W-1:0]  oy_q;

	// divider that rebuilds the output coordinates after a size write
	logic             div_busy_q;
	logic [4:0]       div_cnt_q;
	logic [POS_W-1:0] div_dq_q;
	logic [W_W-1:0]   div_rem_q;
	logic [W_W:0]     div_tmp;
	logic             div_ge;
	logic [W_W-1:0]   div_rem_n;
	logic [POS_W-1:0] div_dq_n;

	// stage 0 decode
	logic             accept;
	logic             wrap0;
	logic [COL_W-1:0] col_e;
	logic [ROW_W-1:0] row_e;
	logic [POS_W-1:0] pos_raw;
	logic             clr;
	logic [COL_W-1:0] col_c;
	logic [ROW_W-1:0] row_c;
	logic [POS_W-1:0] pos_c;
	logic [POS_W-1:0] em_c;
	logic [COL_W-1:0] ox_c;
	logic [OY_W-1:0]  oy_c;
	logic             pix_ph;
	logic             drop;
	logic             push0;
	logic             emit0;
	logic             done0;
	pixel_t           word0;
	logic [W_W:0]     colp;
	logic [W_W:0]     oxp;
	logic [NUM_CELLS-1:0] inv;
	logic [NUM_CELLS-1:0] pad_lo;
	logic [NUM_CELLS-1:0] pad_hi;
	logic [3:0]       n_inv;
	logic [3:0]       n_zero;
	logic [3:0]       seen;
	logic             r0;
	logic             r2;
	logic             c0;
	logic             c2;

	// stage 1
	logic                 s1_valid_q;
	logic [COL_W-1:0]     s1_addr_s1;
	pixel_t               s1_word_s1;
	logic                 s1_emit_s1;
	logic                 s1_done_s1;
	logic [NUM_CELLS-1:0] s1_padlo_s1;
	logic [NUM_CELLS-1:0] s1_padhi_s1;
	logic                 byp_q;
	pixel_t               byp_top_q;
	pixel_t               byp_mid_q;
	logic                 s1_adv;
	pixel_t               top_rd;
	pixel_t               mid_rd;
	pixel_t               top1;
	pixel_t               mid1;
	pixel_t               win_q [NUM_CELLS];
	pixel_t               win_n [NUM_CELLS];

	always_comb begin
		if (image_width < 12'd3) begin
			w = MIN_W;
		end else if (W_W'(image_width) > MAX_W) begin
			w = MAX_W;
		end else begin
			w = W_W'(image_width);
		end
		h = (image_height < 16'd3) ? 16'd3 : image_height;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= RST_TOTAL;
		end else begin
			total_q <= POS_W'(w) * POS_W'(h);
		end
	end

	assign div_busy = div_busy_q;
	assign s1_adv   = s1_valid_q & (!s1_emit_s1 | !q_stat.full);
	// hold input in the cycle of a size write too
	assign in_stall = div_busy_q | size_wr | (s1_valid_q & !s1_adv);
	assign accept   = in_valid & !in_stall;

	always_comb begin
		div_tmp   = {div_rem_q, div_dq_q[POS_W-1]};
		div_ge    = div_tmp >= {1'b0, w};
		div_rem_n = div_ge ? W_W'(div_tmp - {1'b0, w}) : div_tmp[W_W-1:0];
		div_dq_n  = {div_dq_q[POS_W-2:0], div_ge};
	end

	always_comb begin
		wrap0   = W_W'(col_q) >= w;
		col_e   = wrap0 ? '0 : col_q;
		row_e   = wrap0 ? row_q + 1'b1 : row_q;
		pos_raw = POS_W'(row_e) * POS_W'(w) + POS_W'(col_e);
		clr     = (pos_raw > total_q + POS_W'(w)) || (emitted_q >= total_q);
		col_c   = clr ? '0 : col_e;
		row_c   = clr ? '0 : row_e;
		pos_c   = clr ? '0 : pos_raw;
		em_c    = clr ? '0 : emitted_q;
		ox_c    = clr ? '0 : ox_q;
		oy_c    = clr ? '0 : oy_q;
		pix_ph  = pos_c < total_q;
		drop    = pix_ph & in_data.mode;
		push0   = accept & !drop;
		emit0   = pos_c >= POS_W'(w) + 1'b1;
		done0   = (em_c + 1'b1) == total_q;
		colp    = (W_W + 1)'(col_c) + 1'b1;
		oxp     = (W_W + 1)'(ox_c) + 1'b1;
		word0   = '0;
		if (pix_ph) begin
			word0[0*LANE_W +: LANE_W] = LANE_W'(in_data.in_blue[CHANNEL_BITS-1:0]);
			word0[1*LANE_W +: LANE_W] = LANE_W'(in_data.in_green[CHANNEL_BITS-1:0]);
			word0[2*LANE_W +: LANE_W] = LANE_W'(in_data.in_red[CHANNEL_BITS-1:0]);
			word0[3*LANE_W +: LANE_W] = LANE_W'(in_data.in_alpha[CHANNEL_BITS-1:0]);
		end
	end

	// Clip the window to the image, then pad missing cells so that the
	// plain median of nine equals the lower median of the valid ones.
	always_comb begin
		r0 = oy_c == '0;
		r2 = oy_c >= h - 1'b1;
		c0 = ox_c == '0;
		c2 = W_W'(ox_c) >= w - 1'b1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				inv[r*3 + c] = (r == 0 && r0) || (r == 2 && r2) || (c == 0 && c0) || (c == 2 && c2);
			end
		end
		n_inv = '0;
		for (int i = 0; i < NUM_CELLS; i++) begin
			n_inv = n_inv + 4'(inv[i]);
		end
		n_zero = (n_inv == 4'd3) ? 4'd2 : ((n_inv == 4'd5) ? 4'd3 : 4'd0);
		seen   = '0;
		for (int i = 0; i < NUM_CELLS; i++) begin
			pad_lo[i] = inv[i] && (seen < n_zero);
			pad_hi[i] = inv[i] && (seen >= n_zero);
			seen      = seen + 4'(inv[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			emitted_q  <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			div_dq_q   <= '0;
			div_rem_q  <= '0;
		end else begin
			if (size_wr) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= '0;
				div_dq_q   <= emitted_q;
				div_rem_q  <= '0;
			end else if (div_busy_q) begin
				div_dq_q  <= div_dq_n;
				div_rem_q <= div_rem_n;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == 5'd31) begin
					div_busy_q <= 1'b0;
					ox_q       <= COL_W'(div_rem_n);
					oy_q       <= div_dq_n[OY_W-1:0];
				end
			end
			if (accept) begin
				// drop: counters still take the wrap and the restart
				col_q     <= col_c;
				row_q     <= row_c;
				emitted_q <= em_c;
				ox_q      <= ox_c;
				oy_q      <= oy_c;
				if (!drop) begin
					if (colp >= (W_W + 1)'(w)) begin
						col_q <= '0;
						row_q <= row_c + 1'b1;
					end else begin
						col_q <= COL_W'(colp);
					end
					if (emit0) begin
						emitted_q <= em_c + 1'b1;
						if (oxp >= (W_W + 1)'(w)) begin
							ox_q <= '0;
							oy_q <= oy_c + 1'b1;
						end else begin
							ox_q <= COL_W'(oxp);
						end
						if (done0) begin
							col_q     <= '0;
							row_q     <= '0;
							emitted_q <= '0;
							ox_q      <= '0;
							oy_q      <= '0;
						end
					end
				end
			end
		end
	end

	mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_line (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(s1_addr_s1),
		.wdata(mid1),
		.re   (push0),
		.raddr(col_c),
		.rdata(top_rd)
	);

	mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_line (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(s1_addr_s1),
		.wdata(s1_word_s1),
		.re   (push0),
		.raddr(col_c),
		.rdata(mid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (push0) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			s1_addr_s1  <= col_c;
			s1_word_s1  <= word0;
			s1_emit_s1  <= emit0;
			s1_done_s1  <= done0;
			s1_padlo_s1 <= pad_lo;
			s1_padhi_s1 <= pad_hi;
			// forward a write that lands on the address read this edge
			byp_q       <= s1_adv && (s1_addr_s1 == col_c);
			byp_top_q   <= mid1;
			byp_mid_q   <= s1_word_s1;
		end
	end

	assign top1 = byp_q ? byp_top_q : top_rd;
	assign mid1 = byp_q ? byp_mid_q : mid_rd;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_n[r*3 + 0] = win_q[r*3 + 1];
			win_n[r*3 + 1] = win_q[r*3 + 2];
		end
		win_n[2] = top1;
		win_n[5] = mid1;
		win_n[8] = s1_word_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CELLS; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			for (int i = 0; i < NUM_CELLS; i++) begin
				win_q[i] <= win_n[i];
			end
		end
	end

	assign q_push = s1_adv & s1_emit_s1;

	always_comb begin
		for (int i = 0; i < NUM_CELLS; i++) begin
			if (s1_padlo_s1[i]) begin
				q_data.cells[i] = '0;
			end else if (s1_padhi_s1[i]) begin
				q_data.cells[i] = '1;
			end else begin
				q_data.cells[i] = win_n[i];
			end
		end
		q_data.orig = win_n[4];
		q_data.done = s1_done_s1;
	end
endmodule

// ===== rtl/mf3_queue.sv =====
module mf3_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mf3_pkg::q_entry_t  push_data,
	input  logic               pop,
	output mf3_pkg::q_entry_t  pop_data,
	output mf3_pkg::q_status_t stat
);
	import mf3_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);

	q_entry_t         mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign stat.full  = cnt_q == (PTR_W + 1)'(Q_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
		end
	end
endmodule

// ===== rtl/mf3_back.sv =====
module mf3_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mf3_pkg::q_entry_t  q_data,
	input  mf3_pkg::q_status_t q_stat,
	output logic               q_pop,
	input  logic [63:0]        median_bit_mask,
	output logic               out_valid,
	input  logic               out_stall,
	output mf3_pkg::out_item_t out_data
);
	import mf3_pkg::*;

	logic   adv;
	logic   b1_valid_q;
	logic   b2_valid_q;
	logic   out_valid_q;
	sort3_t srt_s1 [NUM_CH][3];
	pixel_t orig_s1;
	logic   done_s1;
	lane_t  lo_s2 [NUM_CH];
	lane_t  md_s2 [NUM_CH];
	lane_t  hi_s2 [NUM_CH];
	pixel_t orig_s2;
	logic   done_s2;
	pixel_t med;
	pixel_t res;
	pixel_t res_q;
	logic   done_q;

	// advance the whole pipe whenever the output register can move
	assign adv   = !out_valid_q | !out_stall;
	assign q_pop = adv & !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			b2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			b1_valid_q  <= q_pop;
			b2_valid_q  <= b1_valid_q;
			out_valid_q <= b2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				for (int r = 0; r < 3; r++) begin
					srt_s1[ch][r] <= sort3(q_data.cells[r*3 + 0][ch*LANE_W +: LANE_W],
						q_data.cells[r*3 + 1][ch*LANE_W +: LANE_W],
						q_data.cells[r*3 + 2][ch*LANE_W +: LANE_W]);
				end
				lo_s2[ch] <= max3(srt_s1[ch][0].lo, srt_s1[ch][1].lo, srt_s1[ch][2].lo);
				md_s2[ch] <= med3(srt_s1[ch][0].md, srt_s1[ch][1].md, srt_s1[ch][2].md);
				hi_s2[ch] <= min3(srt_s1[ch][0].hi, srt_s1[ch][1].hi, srt_s1[ch][2].hi);
			end
			orig_s1 <= q_data.orig;
			done_s1 <= q_data.done;
			orig_s2 <= orig_s1;
			done_s2 <= done_s1;
			res_q   <= res;
			done_q  <= done_s2;
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			med[ch*LANE_W +: LANE_W] = med3(lo_s2[ch], md_s2[ch], hi_s2[ch]);
		end
		res = (med & median_bit_mask) | (orig_s2 & ~median_bit_mask);
	end

	assign out_valid           = out_valid_q;
	assign out_data.out_blue   = res_q[0*LANE_W +: LANE_W];
	assign out_data.out_green  = res_q[1*LANE_W +: LANE_W];
	assign out_data.out_red    = res_q[2*LANE_W +: LANE_W];
	assign out_data.out_alpha  = res_q[3*LANE_W +: LANE_W];
	assign out_data.frame_done = done_q;
endmodule

// ===== rtl/median_filter_3x3_rgba16_top.sv =====
// channel | signals                          | direction | accepted when
// input   | in_valid, in_stall, in_data      | in        | in_valid && !in_stall
// output  | out_valid, out_stall, out_data   | out       | out_valid && !out_stall
// config  | cfg_valid, cfg_ready, cfg_index, | in        | cfg_valid && cfg_ready
//         | cfg_data                         |           |
//
// One item per clock sustained while neither out_stall nor a coordinate rebuild
// holds the input. A result passes the front stage register, the item queue, the
// sort registers srt_s1 and lo/md/hi_s2 and the output register; results lag the
// pixel stream by one line plus one pixel, set by the two line RAMs. A write of
// image_width or image_height starts a divider that rebuilds the output coordinates;
// input stalls in the write cycle and while the divider runs, and config is held until it is done.
// Reset clears counters, window and config to defaults; line RAMs are not
// cleared. Output stall backs up through the 4-entry item queue to the input.
module median_filter_3x3_rgba16_top #(
	parameter int MAX_WIDTH    = 2048,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  mf3_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output mf3_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [63:0]                        cfg_data
);
	import mf3_pkg::*;

	logic [11:0] image_width_q;
	logic [15:0] image_height_q;
	logic [63:0] median_bit_mask_q;
	logic        cfg_wr;
	logic        size_wr;
	logic        div_busy;
	logic        q_push;
	logic        q_pop;
	q_entry_t    q_in;
	q_entry_t    q_out;
	q_status_t   q_stat;

	// hold off config while the coordinate divider runs
	assign cfg_ready = !div_busy;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign size_wr   = cfg_wr &
		((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= RST_IMAGE_WIDTH;
			image_height_q    <= RST_IMAGE_HEIGHT;
			median_bit_mask_q <= RST_MEDIAN_MASK;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[11:0];
				end
				CFG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[15:0];
				end
				CFG_MEDIAN_MASK: begin
					median_bit_mask_q <= cfg_data;
				end
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// front: count positions, run line buffers and window, clip and pad
	mf3_front #(.MAX_WIDTH(MAX_WIDTH), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.size_wr     (size_wr),
		.div_busy    (div_busy),
		.q_push      (q_push),
		.q_data      (q_in),
		.q_stat      (q_stat)
	);

	// queue: decouple the window front from the sorting back
	mf3_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.pop_data (q_out),
		.stat     (q_stat)
	);

	// back: median network per channel, bit mask blend, output register
	mf3_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_data         (q_out),
		.q_stat         (q_stat),
		.q_pop          (q_pop),
		.median_bit_mask(median_bit_mask_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("item pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("item popped from empty queue");

	a_div_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		size_wr |=> (in_stall && !cfg_ready))
		else $error("input or config open during coordinate rebuild");
endmodule
